@@ src/dnsap_pkg.sv @@
// ----------------------------------------------------------------------------
// dnsap_pkg
// Shared types and constants of the DNS A-record response parser.
// ----------------------------------------------------------------------------
package dnsap_pkg;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_Q_LEN,
    PH_Q_LABEL,
    PH_Q_TAIL,
    PH_A_LEN,
    PH_A_PTR,
    PH_A_LABEL,
    PH_A_FIXED,
    PH_A_RDATA,
    PH_A_ADDR
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_TRUNC,
    ST_BAD_ID,
    ST_RCODE,
    ST_NO_ANS,
    ST_BAD_LEN,
    ST_NO_A
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] address;
  } result_t;

  localparam logic [3:0]  HDR_LEN         = 4'd12;
  localparam logic [3:0]  FIXED_LEN       = 4'd10;
  localparam logic [3:0]  TAIL_LEN        = 4'd4;
  localparam logic [3:0]  ADDR_LEN        = 4'd4;
  localparam logic [7:0]  PTR_BITS        = 8'hC0;
  localparam logic [15:0] QR_BIT          = 16'h8000;
  localparam logic [15:0] TC_BIT          = 16'h0200;
  localparam logic [15:0] RCODE_BITS      = 16'h000F;
  localparam logic [31:0] TYPE_CLASS_A_IN = 32'h0001_0001;
  localparam logic [15:0] A_RDLEN         = 16'd4;

  localparam logic REG_EXPECTED_ID = 1'b0;

endpackage

@@ src/dnsap_parser.sv @@
// ----------------------------------------------------------------------------
// dnsap_parser
// Per-packet parse state and the byte decode that yields one status per packet.
// ----------------------------------------------------------------------------
module dnsap_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  dnsap_pkg::item_t   item_i,
  input  logic [15:0]        expected_id_i,
  output logic               res_valid_o,
  output dnsap_pkg::result_t res_o
);

  dnsap_pkg::phase_e phase_q, phase_d;
  logic [3:0]  byte_count_q, byte_count_d;
  logic [15:0] flags_word_q, flags_word_d;
  logic [15:0] questions_left_q, questions_left_d;
  logic [15:0] answers_left_q, answers_left_d;
  logic [15:0] skip_left_q, skip_left_d;
  logic [31:0] type_class_q, type_class_d;
  logic [31:0] addr_shift_q, addr_shift_d;
  logic        decided_q, decided_d;

  logic               res_valid;
  dnsap_pkg::status_e res_status;
  logic [31:0]        res_addr;
  logic [3:0]         cnt_inc;
  logic [7:0]         b;

  assign b       = item_i.data_byte;
  assign cnt_inc = byte_count_q + 4'd1;

  always_comb begin
    phase_d          = phase_q;
    byte_count_d     = byte_count_q;
    flags_word_d     = flags_word_q;
    questions_left_d = questions_left_q;
    answers_left_d   = answers_left_q;
    skip_left_d      = skip_left_q;
    type_class_d     = type_class_q;
    addr_shift_d     = addr_shift_q;
    decided_d        = decided_q;
    res_valid        = 1'b0;
    res_status       = dnsap_pkg::ST_OK;
    res_addr         = 32'd0;

    if (!decided_q) begin
      case (phase_q)
        dnsap_pkg::PH_HEADER: begin
          if (byte_count_q < 4'd2) begin
            type_class_d = {16'd0, type_class_q[7:0], b};
          end else if (byte_count_q < 4'd4) begin
            flags_word_d = {flags_word_q[7:0], b};
          end else if (byte_count_q < 4'd6) begin
            questions_left_d = {questions_left_q[7:0], b};
          end else if (byte_count_q < 4'd8) begin
            answers_left_d = {answers_left_q[7:0], b};
          end
          byte_count_d = cnt_inc;
          if (cnt_inc >= dnsap_pkg::HDR_LEN) begin
            byte_count_d = 4'd0;
            if (type_class_d != {16'd0, expected_id_i} ||
                (flags_word_d & dnsap_pkg::QR_BIT) == 16'd0) begin
              res_valid  = 1'b1;
              res_status = dnsap_pkg::ST_BAD_ID;
            end else if ((flags_word_d & (dnsap_pkg::TC_BIT | dnsap_pkg::RCODE_BITS))
                         != 16'd0) begin
              res_valid  = 1'b1;
              res_status = dnsap_pkg::ST_RCODE;
            end else if (answers_left_d == 16'd0) begin
              res_valid  = 1'b1;
              res_status = dnsap_pkg::ST_NO_ANS;
            end else begin
              phase_d = (questions_left_d == 16'd0) ? dnsap_pkg::PH_A_LEN
                                                    : dnsap_pkg::PH_Q_LEN;
            end
          end
        end
        dnsap_pkg::PH_Q_LEN: begin
          if (b != 8'd0) begin
            skip_left_d = {8'd0, b};
            phase_d     = dnsap_pkg::PH_Q_LABEL;
          end else begin
            byte_count_d = 4'd0;
            phase_d      = dnsap_pkg::PH_Q_TAIL;
          end
        end
        dnsap_pkg::PH_Q_LABEL: begin
          skip_left_d = skip_left_q - 16'd1;
          if (skip_left_d == 16'd0) begin
            phase_d = dnsap_pkg::PH_Q_LEN;
          end
        end
        dnsap_pkg::PH_Q_TAIL: begin
          byte_count_d = cnt_inc;
          if (cnt_inc >= dnsap_pkg::TAIL_LEN) begin
            byte_count_d     = 4'd0;
            questions_left_d = questions_left_q - 16'd1;
            phase_d = (questions_left_d == 16'd0) ? dnsap_pkg::PH_A_LEN
                                                  : dnsap_pkg::PH_Q_LEN;
          end
        end
        dnsap_pkg::PH_A_LEN: begin
          if ((b & dnsap_pkg::PTR_BITS) != 8'd0) begin
            phase_d = dnsap_pkg::PH_A_PTR;
          end else if (b != 8'd0) begin
            skip_left_d = {8'd0, b};
            phase_d     = dnsap_pkg::PH_A_LABEL;
          end else begin
            byte_count_d = 4'd0;
            type_class_d = 32'd0;
            phase_d      = dnsap_pkg::PH_A_FIXED;
          end
        end
        dnsap_pkg::PH_A_PTR: begin
          byte_count_d = 4'd0;
          type_class_d = 32'd0;
          phase_d      = dnsap_pkg::PH_A_FIXED;
        end
        dnsap_pkg::PH_A_LABEL: begin
          skip_left_d = skip_left_q - 16'd1;
          if (skip_left_d == 16'd0) begin
            phase_d = dnsap_pkg::PH_A_LEN;
          end
        end
        dnsap_pkg::PH_A_FIXED: begin
          if (byte_count_q < 4'd4) begin
            type_class_d = {type_class_q[23:0], b};
          end else if (byte_count_q >= 4'd8) begin
            skip_left_d = {skip_left_q[7:0], b};
          end
          byte_count_d = cnt_inc;
          if (cnt_inc >= dnsap_pkg::FIXED_LEN) begin
            byte_count_d = 4'd0;
            if (type_class_d == dnsap_pkg::TYPE_CLASS_A_IN) begin
              if (skip_left_d != dnsap_pkg::A_RDLEN) begin
                res_valid  = 1'b1;
                res_status = dnsap_pkg::ST_BAD_LEN;
              end else begin
                addr_shift_d = 32'd0;
                phase_d      = dnsap_pkg::PH_A_ADDR;
              end
            end else if (skip_left_d == 16'd0) begin
              answers_left_d = answers_left_q - 16'd1;
              if (answers_left_d == 16'd0) begin
                res_valid  = 1'b1;
                res_status = dnsap_pkg::ST_NO_A;
              end else begin
                phase_d = dnsap_pkg::PH_A_LEN;
              end
            end else begin
              phase_d = dnsap_pkg::PH_A_RDATA;
            end
          end
        end
        dnsap_pkg::PH_A_RDATA: begin
          skip_left_d = skip_left_q - 16'd1;
          if (skip_left_d == 16'd0) begin
            answers_left_d = answers_left_q - 16'd1;
            if (answers_left_d == 16'd0) begin
              res_valid  = 1'b1;
              res_status = dnsap_pkg::ST_NO_A;
            end else begin
              phase_d = dnsap_pkg::PH_A_LEN;
            end
          end
        end
        dnsap_pkg::PH_A_ADDR: begin
          addr_shift_d = {addr_shift_q[23:0], b};
          byte_count_d = cnt_inc;
          if (cnt_inc >= dnsap_pkg::ADDR_LEN) begin
            res_valid  = 1'b1;
            res_status = dnsap_pkg::ST_OK;
            res_addr   = addr_shift_d;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
      if (res_valid) begin
        decided_d = 1'b1;
      end
    end

    if (item_i.last_byte && !res_valid && !decided_q) begin
      res_valid  = 1'b1;
      res_status = dnsap_pkg::ST_TRUNC;
    end

    // last byte starts a fresh packet
    if (item_i.last_byte) begin
      phase_d          = dnsap_pkg::PH_HEADER;
      byte_count_d     = 4'd0;
      flags_word_d     = 16'd0;
      questions_left_d = 16'd0;
      answers_left_d   = 16'd0;
      skip_left_d      = 16'd0;
      type_class_d     = 32'd0;
      addr_shift_d     = 32'd0;
      decided_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= dnsap_pkg::PH_HEADER;
      byte_count_q     <= 4'd0;
      flags_word_q     <= 16'd0;
      questions_left_q <= 16'd0;
      answers_left_q   <= 16'd0;
      skip_left_q      <= 16'd0;
      type_class_q     <= 32'd0;
      addr_shift_q     <= 32'd0;
      decided_q        <= 1'b0;
    end else if (step_i) begin
      phase_q          <= phase_d;
      byte_count_q     <= byte_count_d;
      flags_word_q     <= flags_word_d;
      questions_left_q <= questions_left_d;
      answers_left_q   <= answers_left_d;
      skip_left_q      <= skip_left_d;
      type_class_q     <= type_class_d;
      addr_shift_q     <= addr_shift_d;
      decided_q        <= decided_d;
    end
  end

  assign res_valid_o   = res_valid;
  assign res_o.status  = res_status;
  assign res_o.address = res_addr;

endmodule

@@ src/dns_a_record_response_parser_unit.sv @@
// ----------------------------------------------------------------------------
// dns_a_record_response_parser_unit
// DNS response parser that extracts the first IN class A address of a packet.
// ----------------------------------------------------------------------------
// Takes one payload byte per cycle (tlast on the final byte) and gives one
// status item per packet, either at the byte that decides the outcome or at
// the last byte. Each byte passes an input register, a combinational decode
// against the parse state, and an output register that holds the status item
// of the deciding byte, and a byte is accepted every cycle while the output
// side keeps up. Write the expected request id at address 0 before the packet
// starts.
module dns_a_record_response_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [2:0] status, [34:3] address, [39:35] zero
);

  logic [15:0]        expected_id_q;
  logic               reg_sel;

  logic               in_valid_q;
  dnsap_pkg::item_t   in_item_q;
  logic               advance;

  logic               res_valid;
  dnsap_pkg::result_t res;

  logic               out_valid_q;
  dnsap_pkg::result_t out_q;

  // configuration register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == dnsap_pkg::REG_EXPECTED_ID);
  assign prdata  = reg_sel ? {16'd0, expected_id_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_id_q <= 16'd0;
    end else if (psel && penable && pwrite && reg_sel) begin
      expected_id_q <= pwdata[15:0];
    end
  end

  // input register
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.data_byte <= s_axis_tdata;
      in_item_q.last_byte <= s_axis_tlast;
    end
  end

  dnsap_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .item_i        (in_item_q),
    .expected_id_i (expected_id_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.address, out_q.status};

  a_nonok_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.status == dnsap_pkg::ST_OK || out_q.address == 32'd0))
    else $error("non-ok status carries an address");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_valid) |=> out_valid_q)
    else $error("decoded status not registered");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready) |=> in_valid_q)
    else $error("input item dropped while output stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.status <= dnsap_pkg::ST_NO_A))
    else $error("status code out of range");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the DNS A-record response parser.
// ----------------------------------------------------------------------------
// Feeds directed and random DNS response packets into the parser, one byte
// per item, and compares every status item with a byte-level model of the
// parse, or with the given status of a directed row. Both streams idle at
// random, and the request id is rewritten between groups of packets.
// ----------------------------------------------------------------------------
module tb;

  localparam int NUM_ITEMS   = 1300;
  localparam int QUIET_ITEMS = 1050;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tlast;   // last_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [2:0] status, [34:3] address, [39:35] zero

  typedef struct {
    logic [7:0]         data;
    logic               last;
    bit                 typed;
    bit                 has_res;
    dnsap_pkg::result_t res;
  } dir_row_t;

  dir_row_t           dir_rows[$];
  dnsap_pkg::result_t pending_status_q[$];
  logic [7:0]         pkt_bytes[$];
  int                 items_sent;
  int                 err_cnt;
  bit                 idle_on;

  logic [15:0]       cfg_id;
  dnsap_pkg::phase_e m_phase;
  logic [3:0]        m_pos;
  logic [15:0]       m_flags;
  logic [15:0]       m_qd_left;
  logic [15:0]       m_an_left;
  logic [15:0]       m_skip;
  logic [31:0]       m_tc;
  logic [31:0]       m_ip;
  bit                m_done;

  dns_a_record_response_parser_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic void dns_clear_packet();
    m_phase   = dnsap_pkg::PH_HEADER;
    m_pos     = '0;
    m_flags   = '0;
    m_qd_left = '0;
    m_an_left = '0;
    m_skip    = '0;
    m_tc      = '0;
    m_ip      = '0;
    m_done    = 1'b0;
  endfunction

  function automatic int dns_end_record();
    m_an_left = m_an_left - 16'd1;
    if (m_an_left == '0) return int'(dnsap_pkg::ST_NO_A);
    m_phase = dnsap_pkg::PH_A_LEN;
    return -1;
  endfunction

  function automatic int dns_consume(input logic [7:0] b);
    case (m_phase)
      dnsap_pkg::PH_HEADER: begin
        if (m_pos < 4'd2) m_tc = {16'h0, m_tc[7:0], b};
        else if (m_pos < 4'd4) m_flags = {m_flags[7:0], b};
        else if (m_pos < 4'd6) m_qd_left = {m_qd_left[7:0], b};
        else if (m_pos < 4'd8) m_an_left = {m_an_left[7:0], b};
        m_pos = m_pos + 4'd1;
        if (m_pos < dnsap_pkg::HDR_LEN) return -1;
        m_pos = '0;
        if (m_tc[15:0] != cfg_id || (m_flags & dnsap_pkg::QR_BIT) == '0)
          return int'(dnsap_pkg::ST_BAD_ID);
        if ((m_flags & (dnsap_pkg::TC_BIT | dnsap_pkg::RCODE_BITS)) != '0)
          return int'(dnsap_pkg::ST_RCODE);
        if (m_an_left == '0) return int'(dnsap_pkg::ST_NO_ANS);
        m_phase = (m_qd_left == '0) ? dnsap_pkg::PH_A_LEN : dnsap_pkg::PH_Q_LEN;
      end
      dnsap_pkg::PH_Q_LEN: begin
        if (b != '0) begin
          m_skip  = {8'h0, b};
          m_phase = dnsap_pkg::PH_Q_LABEL;
        end else begin
          m_pos   = '0;
          m_phase = dnsap_pkg::PH_Q_TAIL;
        end
      end
      dnsap_pkg::PH_Q_LABEL: begin
        m_skip = m_skip - 16'd1;
        if (m_skip == '0) m_phase = dnsap_pkg::PH_Q_LEN;
      end
      dnsap_pkg::PH_Q_TAIL: begin
        m_pos = m_pos + 4'd1;
        if (m_pos >= dnsap_pkg::TAIL_LEN) begin
          m_pos     = '0;
          m_qd_left = m_qd_left - 16'd1;
          m_phase   = (m_qd_left == '0) ? dnsap_pkg::PH_A_LEN : dnsap_pkg::PH_Q_LEN;
        end
      end
      dnsap_pkg::PH_A_LEN: begin
        if ((b & dnsap_pkg::PTR_BITS) != '0) begin
          m_phase = dnsap_pkg::PH_A_PTR;
        end else if (b != '0) begin
          m_skip  = {8'h0, b};
          m_phase = dnsap_pkg::PH_A_LABEL;
        end else begin
          m_pos   = '0;
          m_tc    = '0;
          m_phase = dnsap_pkg::PH_A_FIXED;
        end
      end
      dnsap_pkg::PH_A_PTR: begin
        m_pos   = '0;
        m_tc    = '0;
        m_phase = dnsap_pkg::PH_A_FIXED;
      end
      dnsap_pkg::PH_A_LABEL: begin
        m_skip = m_skip - 16'd1;
        if (m_skip == '0) m_phase = dnsap_pkg::PH_A_LEN;
      end
      dnsap_pkg::PH_A_FIXED: begin
        if (m_pos < 4'd4) m_tc = {m_tc[23:0], b};
        else if (m_pos >= 4'd8) m_skip = {m_skip[7:0], b};
        m_pos = m_pos + 4'd1;
        if (m_pos < dnsap_pkg::FIXED_LEN) return -1;
        m_pos = '0;
        if (m_tc == dnsap_pkg::TYPE_CLASS_A_IN) begin
          if (m_skip != dnsap_pkg::A_RDLEN) return int'(dnsap_pkg::ST_BAD_LEN);
          m_ip    = '0;
          m_phase = dnsap_pkg::PH_A_ADDR;
          return -1;
        end
        if (m_skip == '0) return dns_end_record();
        m_phase = dnsap_pkg::PH_A_RDATA;
      end
      dnsap_pkg::PH_A_RDATA: begin
        m_skip = m_skip - 16'd1;
        if (m_skip == '0) return dns_end_record();
      end
      dnsap_pkg::PH_A_ADDR: begin
        m_ip  = {m_ip[23:0], b};
        m_pos = m_pos + 4'd1;
        if (m_pos >= dnsap_pkg::ADDR_LEN) return int'(dnsap_pkg::ST_OK);
      end
      default: ;
    endcase
    return -1;
  endfunction

  function automatic bit dns_parse_byte(input logic [7:0] b, input logic last,
                                        output dnsap_pkg::result_t res);
    int st;
    st  = -1;
    res = '0;
    if (!m_done) begin
      st = dns_consume(b);
      if (st >= 0) m_done = 1'b1;
    end
    if (last && st < 0 && !m_done) st = int'(dnsap_pkg::ST_TRUNC);
    if (st >= 0) begin
      res.status  = dnsap_pkg::status_e'(st[2:0]);
      res.address = (st == int'(dnsap_pkg::ST_OK)) ? m_ip : '0;
    end
    if (last) dns_clear_packet();
    return st >= 0;
  endfunction

  function automatic void add_row(input logic [7:0] d, input logic l, input bit typed,
                                  input bit has, input dnsap_pkg::status_e st);
    dir_row_t row;
    row.data        = d;
    row.last        = l;
    row.typed       = typed;
    row.has_res     = has;
    row.res.status  = st;
    row.res.address = '0;
    dir_rows.push_back(row);
  endfunction

  task automatic push_bytes(input int n);
    repeat (n) pkt_bytes.push_back(8'($urandom));
  endtask

  task automatic build_dns_packet();
    int          nq;
    int          na;
    int          len;
    int          cut;
    bit          a_in;
    logic [15:0] id;
    logic [15:0] flags;
    logic [15:0] rdl;
    pkt_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      push_bytes($urandom_range(1, 24));
      return;
    end
    id    = ($urandom_range(0, 9) == 0) ? 16'($urandom) : cfg_id;
    flags = 16'h8180;
    case ($urandom_range(0, 11))
      0: flags = 16'($urandom);
      1: flags = flags | dnsap_pkg::TC_BIT;
      2: flags = flags | 16'($urandom_range(1, 15));
      3: flags = flags & ~dnsap_pkg::QR_BIT;
      default: ;
    endcase
    nq = $urandom_range(0, 2);
    na = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 3);
    pkt_bytes.push_back(id[15:8]);
    pkt_bytes.push_back(id[7:0]);
    pkt_bytes.push_back(flags[15:8]);
    pkt_bytes.push_back(flags[7:0]);
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'(nq));
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'(na));
    push_bytes(4);
    repeat (nq) begin
      repeat ($urandom_range(0, 3)) begin
        len = $urandom_range(1, 5);
        pkt_bytes.push_back(8'(len));
        push_bytes(len);
      end
      pkt_bytes.push_back(8'h00);
      push_bytes(4);
    end
    repeat (na) begin
      if ($urandom_range(0, 2) != 0) begin
        repeat ($urandom_range(1, 3)) begin
          len = $urandom_range(1, 5);
          pkt_bytes.push_back(8'(len));
          push_bytes(len);
        end
      end
      if ($urandom_range(0, 1) == 0) begin
        pkt_bytes.push_back(8'($urandom_range(64, 255)));
        push_bytes(1);
      end else begin
        pkt_bytes.push_back(8'h00);
      end
      a_in = 1'($urandom_range(0, 1));
      if (a_in) begin
        pkt_bytes.push_back(dnsap_pkg::TYPE_CLASS_A_IN[31:24]);
        pkt_bytes.push_back(dnsap_pkg::TYPE_CLASS_A_IN[23:16]);
        pkt_bytes.push_back(dnsap_pkg::TYPE_CLASS_A_IN[15:8]);
        pkt_bytes.push_back(dnsap_pkg::TYPE_CLASS_A_IN[7:0]);
      end else begin
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'($urandom_range(2, 16)));
        push_bytes(2);
      end
      push_bytes(4);
      if (a_in && $urandom_range(0, 5) == 0) begin
        rdl = 16'($urandom);
        if (rdl == dnsap_pkg::A_RDLEN) rdl = 16'd5;
      end else if (a_in) begin
        rdl = dnsap_pkg::A_RDLEN;
      end else begin
        rdl = 16'($urandom_range(0, 6));
      end
      pkt_bytes.push_back(rdl[15:8]);
      pkt_bytes.push_back(rdl[7:0]);
      push_bytes((rdl > 16'd8) ? 2 : int'(rdl));
    end
    push_bytes($urandom_range(0, 3));
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, pkt_bytes.size() - 1);
      while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
    end
  endtask

  task automatic send_item(input logic [7:0] d, input logic l, input bit typed,
                           input bit typed_has, input dnsap_pkg::result_t typed_res);
    dnsap_pkg::result_t pred;
    bit                 has;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = d;
    s_axis_tlast  = l;
    do @(posedge clk_i); while (!s_axis_tready);
    has = dns_parse_byte(d, l, pred);
    if (typed) begin
      has  = typed_has;
      pred = typed_res;
    end
    if (has) pending_status_q.push_back(pred);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic cfg_access(input bit wr, input logic [31:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {dnsap_pkg::REG_EXPECTED_ID, 2'b00};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (wr) begin
      cfg_id = val[15:0];
    end else if (prdata[15:0] !== cfg_id) begin
      $display("%0t: expected_id read expected %h got %h", $time, cfg_id, prdata[15:0]);
      err_cnt++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic wait_idle();
    int spins;
    spins         = 0;
    s_axis_tvalid = 1'b0;
    while (pending_status_q.size() != 0 && spins < 5000) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    dnsap_pkg::result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_status_q.size() == 0) begin
        $display("%0t: unexpected status item, expected none got %h", $time, m_axis_tdata);
        err_cnt++;
      end else begin
        exp_res = pending_status_q.pop_front();
        if (m_axis_tdata[2:0] !== exp_res.status) begin
          $display("%0t: status expected %0d got %0d", $time, exp_res.status,
                   m_axis_tdata[2:0]);
          err_cnt++;
        end
        if (m_axis_tdata[34:3] !== exp_res.address) begin
          $display("%0t: address expected %h got %h", $time, exp_res.address,
                   m_axis_tdata[34:3]);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    logic [15:0] next_id;
    int          grp;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    items_sent    = 0;
    err_cnt       = 0;
    idle_on       = 1'b1;
    cfg_id        = '0;
    dns_clear_packet();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // lone last byte right after reset
    add_row(8'h00, 1'b1, 1'b1, 1'b1, dnsap_pkg::ST_TRUNC);
    // id ffff against the reset id, decided on the last byte
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, dnsap_pkg::ST_OK);
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, dnsap_pkg::ST_OK);
    add_row(8'h80, 1'b0, 1'b0, 1'b0, dnsap_pkg::ST_OK);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, dnsap_pkg::ST_OK);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, dnsap_pkg::ST_OK);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, dnsap_pkg::ST_OK);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, dnsap_pkg::ST_OK);
    add_row(8'h01, 1'b0, 1'b0, 1'b0, dnsap_pkg::ST_OK);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, dnsap_pkg::ST_OK);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, dnsap_pkg::ST_OK);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, dnsap_pkg::ST_OK);
    add_row(8'h00, 1'b1, 1'b1, 1'b1, dnsap_pkg::ST_BAD_ID);
    // rcode set, then a byte after the decision
    add_row(8'h00, 1'b0, 1'b0, 1'b0, dnsap_pkg::ST_OK);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, dnsap_pkg::ST_OK);
    add_row(8'h81, 1'b0, 1'b0, 1'b0, dnsap_pkg::ST_OK);
    add_row(8'h0F, 1'b0, 1'b0, 1'b0, dnsap_pkg::ST_OK);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, dnsap_pkg::ST_OK);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, dnsap_pkg::ST_OK);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, dnsap_pkg::ST_OK);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, dnsap_pkg::ST_OK);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, dnsap_pkg::ST_OK);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, dnsap_pkg::ST_OK);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, dnsap_pkg::ST_OK);
    add_row(8'h00, 1'b0, 1'b1, 1'b1, dnsap_pkg::ST_RCODE);
    add_row(8'hFF, 1'b1, 1'b1, 1'b0, dnsap_pkg::ST_OK);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
                dir_rows[i].has_res, dir_rows[i].res);
    end

    grp = 0;
    while (items_sent < NUM_ITEMS) begin
      wait_idle();
      case (grp)
        0:       next_id = 16'hFFFF;
        1:       next_id = 16'h0000;
        default: next_id = 16'($urandom);
      endcase
      cfg_access(1'b1, {16'($urandom), next_id});
      cfg_access(1'b0, '0);
      idle_on = (items_sent < QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < 8 && items_sent < NUM_ITEMS; k++) begin
        build_dns_packet();
        foreach (pkt_bytes[j]) begin
          send_item(pkt_bytes[j], j == pkt_bytes.size() - 1, 1'b0, 1'b0, '0);
        end
      end
      grp++;
    end

    wait_idle();
    if (pending_status_q.size() != 0) begin
      $display("%0t: %0d expected status items never arrived", $time,
               pending_status_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
